@@ rtl/core/mouse_delta_normalizer_top_defines.svh @@
// Assertion macros shared by the normalizer RTL.
`ifndef MOUSE_DELTA_NORMALIZER_TOP_DEFINES_SVH
`define MOUSE_DELTA_NORMALIZER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define MDN_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mdn check failed");

// Next-cycle implication, checked outside reset
`define MDN_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mdn check failed");

`endif

@@ rtl/core/mdn_pkg.sv @@
`timescale 1ns / 1ps

package mdn_pkg;

  // Delta field width
  localparam int DELTA_BITS = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DPI_W      = 14;
  localparam int PS_W       = 16;
  localparam int HZ_W       = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL_ENABLE  = 3'd0,
    REG_MOUSE_DPI     = 3'd1,
    REG_REF_DPI       = 3'd2,
    REG_POINTER_SCALE = 3'd3,
    REG_REFRESH_RATE  = 3'd4,
    REG_REF_HZ        = 3'd5
  } cfg_reg_e;

  localparam logic [DPI_W-1:0] DPI_MIN   = 14'd100;
  localparam logic [DPI_W-1:0] DPI_MAX   = 14'd16000;
  localparam logic [DPI_W-1:0] DPI_RST   = 14'd800;
  localparam logic [PS_W-1:0]  PS_RST    = 16'd4096;
  localparam logic [HZ_W-1:0]  HZ_MIN    = 9'd30;
  localparam logic [HZ_W-1:0]  HZ_MAX    = 9'd500;
  localparam logic [HZ_W-1:0]  HZ_RST    = 9'd60;

  // Curve numerator and factor widths
  localparam int F_NUM_W  = 25;
  localparam int F_W      = 21;
  localparam int H_W      = 17;

  // Curve pieces: knees, offsets and reciprocals of the constant divisors
  // (ceil(2^27 / d); exact floor quotient for every numerator of its piece)
  localparam logic [15:0] CURVE_KNEE_LO = 16'd896;
  localparam logic [15:0] CURVE_KNEE_HI = 16'd1792;
  localparam logic [15:0] CURVE_P1_OFS  = 16'd1344;
  localparam logic [F_NUM_W-1:0] CURVE_P3_MUL = 25'd96;
  localparam logic [F_NUM_W-1:0] CURVE_P1_RCP = 25'd3834793;
  localparam logic [F_NUM_W-1:0] CURVE_P2_RCP = 25'd19173962;
  localparam logic [F_NUM_W-1:0] CURVE_P3_RCP = 25'd26843546;
  localparam int                 CURVE_RCP_SH = 27;
  localparam logic [F_W-1:0]     CURVE_ONE    = 21'd65536;
  localparam logic [F_W-1:0]     CURVE_MIN    = 21'd19660;

  localparam logic [H_W-1:0] HZ_LOW  = 17'd49152;
  localparam logic [H_W-1:0] HZ_HIGH = 17'd81920;

  // Scaling chain widths
  localparam int S1_NUM_W = DELTA_BITS + 28;
  localparam int S1_W     = DELTA_BITS + 14;
  localparam int S2_W     = DELTA_BITS + 22;
  localparam int S3_W     = 37;
  localparam int S4_W     = 34;
  localparam logic [S3_W-1:0] S3_LIMIT = 37'h10_0000_0000;

  // Item formats
  typedef struct packed {
    logic signed [DELTA_BITS-1:0] delta_x;
    logic signed [DELTA_BITS-1:0] delta_y;
    logic [15:0]                  velocity_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] norm_x;
    logic signed [31:0] norm_y;
    logic [31:0]        velocity_out;
  } out_item_t;

endpackage

@@ rtl/core/mouse_delta_normalizer_top.sv @@
// An item passes the Hz divider, stages P, Q, A, the lane chains and the root pipe.
// Throughput: one item per cycle; busy stays low, items stream back to back.
// Most depth is in the pipelined dividers (Hz factor, |d|/F, DPI) and the root pipe.
// Reset (rst, synchronous): clears all stage valid bits and loads the register
// defaults; no result is pending afterwards. The receiver cannot stall done.
`timescale 1ns / 1ps
`include "mouse_delta_normalizer_top_defines.svh"

module mouse_delta_normalizer_top import mdn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              item,
  output logic                  done,
  output out_item_t             result,
  input  logic                  cfg_wr,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DB   = DELTA_BITS;
  localparam int HS_W = 2*DB + 17;

  // ---------------- configuration registers ----------------
  logic             accel_enable;
  logic [DPI_W-1:0] mouse_dpi;
  logic [DPI_W-1:0] ref_dpi;
  logic [PS_W-1:0]  pointer_scale;
  logic [HZ_W-1:0]  refresh_rate;
  logic [HZ_W-1:0]  ref_hz;

  logic [DPI_W-1:0] dpi_wr;
  logic [HZ_W-1:0]  hz_wr;

  // Clamp the divisor registers on write
  always_comb begin
    dpi_wr = cfg_wdata[DPI_W-1:0];
    if (dpi_wr < DPI_MIN) begin
      dpi_wr = DPI_MIN;
    end else if (dpi_wr > DPI_MAX) begin
      dpi_wr = DPI_MAX;
    end
    hz_wr = cfg_wdata[HZ_W-1:0];
    if (hz_wr < HZ_MIN) begin
      hz_wr = HZ_MIN;
    end else if (hz_wr > HZ_MAX) begin
      hz_wr = HZ_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_enable  <= 1'b0;
      mouse_dpi     <= DPI_RST;
      ref_dpi       <= DPI_RST;
      pointer_scale <= PS_RST;
      refresh_rate  <= HZ_RST;
      ref_hz        <= HZ_RST;
    end else if (cfg_wr) begin
      case (cfg_addr)
        REG_ACCEL_ENABLE:  accel_enable  <= cfg_wdata[0];
        REG_MOUSE_DPI:     mouse_dpi     <= dpi_wr;
        REG_REF_DPI:       ref_dpi       <= cfg_wdata[DPI_W-1:0];
        REG_POINTER_SCALE: pointer_scale <= cfg_wdata[PS_W-1:0];
        REG_REFRESH_RATE:  refresh_rate  <= hz_wr;
        REG_REF_HZ:        ref_hz        <= cfg_wdata[HZ_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline never holds off an item
  assign busy = 1'b0;

  logic in_valid;
  assign in_valid = start & ~busy;

  // ---------------- Hz factor divider ----------------
  logic               hdiv_valid;
  logic [F_NUM_W-1:0] hdiv_quo;
  logic [HS_W-1:0]    hdiv_side;

  // Item fields and the curve enable ride along with the quotient
  mdn_div #(.NW(F_NUM_W), .DW(HZ_W), .SW(HS_W)) u_hdiv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .num       ({ref_hz, 16'b0}),
    .den       (refresh_rate),
    .side_in   ({accel_enable, item.velocity_in, item.delta_x, item.delta_y}),
    .out_valid (hdiv_valid),
    .quo       (hdiv_quo),
    .side_out  (hdiv_side)
  );

  // ---------------- stage P: curve piece, Hz clamp, magnitudes ----------------
  logic               valid_p;
  logic [F_NUM_W-1:0] x_p;
  logic [F_NUM_W-1:0] rcp_p;
  logic               p3_p;
  logic               acc_p;
  logic [H_W-1:0]     h_p;
  logic [DB-1:0]      mag_p [0:1];
  logic               neg_p [0:1];

  logic [15:0]        vel_h;
  logic [F_NUM_W-1:0] x_sel;
  logic [F_NUM_W-1:0] rcp_sel;
  logic               p3_sel;
  logic [H_W-1:0]     h_sel;
  logic [DB-1:0]      d_raw [0:1];

  // Pick the curve piece: numerator and reciprocal of its constant divisor
  always_comb begin
    vel_h  = hdiv_side[2*DB+15:2*DB];
    p3_sel = 1'b0;
    if (vel_h < CURVE_KNEE_LO) begin
      x_sel   = F_NUM_W'(vel_h + CURVE_P1_OFS) << 9;
      rcp_sel = CURVE_P1_RCP;
    end else if (vel_h < CURVE_KNEE_HI) begin
      x_sel   = F_NUM_W'(vel_h) << 8;
      rcp_sel = CURVE_P2_RCP;
    end else begin
      x_sel   = F_NUM_W'(vel_h - CURVE_KNEE_HI) * CURVE_P3_MUL;
      rcp_sel = CURVE_P3_RCP;
      p3_sel  = 1'b1;
    end
    if (hdiv_quo < F_NUM_W'(HZ_LOW)) begin
      h_sel = HZ_LOW;
    end else if (hdiv_quo > F_NUM_W'(HZ_HIGH)) begin
      h_sel = HZ_HIGH;
    end else begin
      h_sel = hdiv_quo[H_W-1:0];
    end
    d_raw[0] = hdiv_side[2*DB-1:DB];
    d_raw[1] = hdiv_side[DB-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_p <= 1'b0;
    end else begin
      valid_p <= hdiv_valid;
    end
  end

  always_ff @(posedge clk) begin
    x_p   <= x_sel;
    rcp_p <= rcp_sel;
    p3_p  <= p3_sel;
    acc_p <= hdiv_side[HS_W-1];
    h_p   <= h_sel;
    for (int i = 0; i < 2; i++) begin
      neg_p[i] <= d_raw[i][DB-1];
      mag_p[i] <= d_raw[i][DB-1] ? (~d_raw[i] + 1'b1) : d_raw[i];
    end
  end

  // ---------------- stage Q: reciprocal multiply ----------------
  logic                 valid_q;
  logic [2*F_NUM_W-1:0] prod_q;
  logic                 p3_q;
  logic                 acc_q;
  logic [H_W-1:0]       h_q;
  logic [DB-1:0]        mag_q [0:1];
  logic                 neg_q [0:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_p;
    end
  end

  always_ff @(posedge clk) begin
    prod_q <= x_p * rcp_p;
    p3_q   <= p3_p;
    acc_q  <= acc_p;
    h_q    <= h_p;
    for (int i = 0; i < 2; i++) begin
      mag_q[i] <= mag_p[i];
      neg_q[i] <= neg_p[i];
    end
  end

  // ---------------- stage A: curve factor ----------------
  logic           valid_a;
  logic [F_W-1:0] f_a;
  logic [H_W-1:0] h_a;
  logic [DB-1:0]  mag_a [0:1];
  logic           neg_a [0:1];

  logic [F_W-1:0] f_sel;

  always_comb begin
    f_sel = prod_q[CURVE_RCP_SH+F_W-1:CURVE_RCP_SH];
    if (p3_q) begin
      f_sel = f_sel + CURVE_ONE;
    end
    if (!acc_q) begin
      f_sel = CURVE_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else begin
      valid_a <= valid_q;
    end
  end

  always_ff @(posedge clk) begin
    f_a <= f_sel;
    h_a <= h_q;
    for (int i = 0; i < 2; i++) begin
      neg_a[i] <= neg_q[i];
      mag_a[i] <= mag_q[i];
    end
  end

  // ---------------- per-lane scaling chain ----------------
  logic        e_valid [0:1];
  logic [31:0] e_mag   [0:1];
  logic [31:0] e_norm  [0:1];

  for (genvar ln = 0; ln < 2; ln++) begin : g_lane
    logic                s1_valid;
    logic [S1_NUM_W-1:0] s1_quo;
    logic [H_W:0]        s1_side;
    logic                b_valid;
    logic [S1_NUM_W-1:0] b_prod;
    logic [H_W:0]        b_side;
    logic                s2_valid;
    logic [S1_NUM_W-1:0] s2_quo;
    logic [H_W:0]        s2_side;
    logic                c_valid;
    logic [S3_W-1:0]     c_s3;
    logic [H_W:0]        c_side;
    logic [S2_W+PS_W-1:0] c_prod;
    logic [S2_W+3:0]     c_shift;
    logic                d_valid;
    logic [S4_W-1:0]     d_s4;
    logic                d_neg;
    logic [S3_W+H_W-1:0] d_prod;
    logic [S4_W-1:0]     e_lim;
    logic [31:0]         e_sat;

    // s1 = |d| * 2^28 / F
    mdn_div #(.NW(S1_NUM_W), .DW(F_W), .SW(H_W+1)) u_s1 (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid_a),
      .num       ({mag_a[ln], 28'b0}),
      .den       (f_a),
      .side_in   ({h_a, neg_a[ln]}),
      .out_valid (s1_valid),
      .quo       (s1_quo),
      .side_out  (s1_side)
    );

    // Stage B: times reference DPI
    always_ff @(posedge clk) begin
      if (rst) begin
        b_valid <= 1'b0;
      end else begin
        b_valid <= s1_valid;
      end
    end

    always_ff @(posedge clk) begin
      b_prod <= S1_NUM_W'(s1_quo[S1_W-1:0] * ref_dpi);
      b_side <= s1_side;
    end

    // s2 = s1 * reference DPI / mouse_dpi
    mdn_div #(.NW(S1_NUM_W), .DW(DPI_W), .SW(H_W+1)) u_s2 (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (b_valid),
      .num       (b_prod),
      .den       (mouse_dpi),
      .side_in   (b_side),
      .out_valid (s2_valid),
      .quo       (s2_quo),
      .side_out  (s2_side)
    );

    // Stage C: pointer scale, Q4.12, then cap
    always_comb begin
      c_prod  = s2_quo[S2_W-1:0] * pointer_scale;
      c_shift = c_prod[S2_W+PS_W-1:12];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        c_valid <= 1'b0;
      end else begin
        c_valid <= s2_valid;
      end
    end

    always_ff @(posedge clk) begin
      c_s3   <= (c_shift > (S2_W+4)'(S3_LIMIT)) ? S3_LIMIT : c_shift[S3_W-1:0];
      c_side <= s2_side;
    end

    // Stage D: Hz factor, Q16.16, and drop to Q8
    always_comb begin
      d_prod = c_s3 * c_side[H_W:1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        d_valid <= 1'b0;
      end else begin
        d_valid <= c_valid;
      end
    end

    always_ff @(posedge clk) begin
      d_s4  <= d_prod[S3_W+H_W-1:20];
      d_neg <= c_side[0];
    end

    // Stage E: saturate and apply sign
    always_comb begin
      e_lim = d_neg ? S4_W'(32'h8000_0000) : S4_W'(32'h7FFF_FFFF);
      e_sat = (d_s4 > e_lim) ? e_lim[31:0] : d_s4[31:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        e_valid[ln] <= 1'b0;
      end else begin
        e_valid[ln] <= d_valid;
      end
    end

    always_ff @(posedge clk) begin
      e_mag[ln]  <= e_sat;
      e_norm[ln] <= d_neg ? (~e_sat + 32'd1) : e_sat;
    end
  end

  // ---------------- squares, sum, root ----------------
  logic        sq_valid;
  logic [63:0] sq [0:1];
  logic [31:0] sq_norm [0:1];
  logic        sum_valid;
  logic [63:0] sum;
  logic [63:0] sum_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid  <= 1'b0;
      sum_valid <= 1'b0;
    end else begin
      sq_valid  <= e_valid[0];
      sum_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      sq[i]      <= e_mag[i] * e_mag[i];
      sq_norm[i] <= e_norm[i];
    end
    sum      <= sq[0] + sq[1];
    sum_side <= {sq_norm[0], sq_norm[1]};
  end

  logic        rt_valid;
  logic [31:0] rt_root;
  logic [63:0] rt_side;

  mdn_isqrt #(.SW(64)) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_valid),
    .radicand  (sum),
    .side_in   (sum_side),
    .out_valid (rt_valid),
    .root      (rt_root),
    .side_out  (rt_side)
  );

  // Result strobe straight from the root pipe's last stage
  assign done                = rt_valid;
  assign result.norm_x       = rt_side[63:32];
  assign result.norm_y       = rt_side[31:0];
  assign result.velocity_out = rt_root;

  // ---------------- checks ----------------
  `MDN_ASSERT_IMP(a_lanes_aligned, 1'b1, e_valid[0] == e_valid[1])
  `MDN_ASSERT_IMP(a_hz_clamped, valid_a, (h_a >= HZ_LOW) && (h_a <= HZ_HIGH))
  `MDN_ASSERT_IMP(a_curve_floor, valid_a, f_a >= CURVE_MIN)
  `MDN_ASSERT_NXT(a_sat_mag, e_valid[0], sq[0] <= 64'h4000_0000_0000_0000)

endmodule

@@ rtl/core/mdn_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per pipeline stage.
module mdn_div import mdn_pkg::*; #(
  parameter int NW = F_NUM_W,
  parameter int DW = HZ_W,
  parameter int SW = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [NW-1:0] quo,
  output logic [SW-1:0] side_out
);

  logic          vld [0:NW];
  logic [DW-1:0] rem [0:NW];
  logic [NW-1:0] nq  [0:NW];
  logic [DW-1:0] dv  [0:NW];
  logic [SW-1:0] sd  [0:NW];

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem[0] <= '0;
    nq[0]  <= num;
    dv[0]  <= den;
    sd[0]  <= side_in;
  end

  // One step per stage: dividend shifts out the top, quotient in the bottom
  for (genvar k = 0; k < NW; k++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        take;

    always_comb begin
      trial = {rem[k], nq[k][NW-1]};
      diff  = trial - {1'b0, dv[k]};
      take  = (trial >= {1'b0, dv[k]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      rem[k+1] <= take ? diff[DW-1:0] : trial[DW-1:0];
      nq[k+1]  <= {nq[k][NW-2:0], take};
      dv[k+1]  <= dv[k];
      sd[k+1]  <= sd[k];
    end
  end

  assign out_valid = vld[NW];
  assign quo       = nq[NW];
  assign side_out  = sd[NW];

endmodule

@@ rtl/core/mdn_isqrt.sv @@
`timescale 1ns / 1ps

// 64-bit integer square root, one root bit per pipeline stage.
module mdn_isqrt import mdn_pkg::*; #(
  parameter int SW = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [63:0]   radicand,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [31:0]   root,
  output logic [SW-1:0] side_out
);

  localparam int STEPS = 32;
  localparam int RW    = 34;

  logic          vld [0:STEPS];
  logic [63:0]   xs  [0:STEPS];
  logic [RW-1:0] rem [0:STEPS];
  logic [31:0]   rt  [0:STEPS];
  logic [SW-1:0] sd  [0:STEPS];

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    xs[0]  <= radicand;
    rem[0] <= '0;
    rt[0]  <= '0;
    sd[0]  <= side_in;
  end

  // Digit-by-digit: bring down two bits, try root*4+1
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [RW+1:0] trial;
    logic [RW+1:0] tst;
    logic [RW+1:0] diff;
    logic          take;

    always_comb begin
      trial = {rem[k], xs[k][63:62]};
      tst   = {2'b00, rt[k], 2'b01};
      diff  = trial - tst;
      take  = (trial >= tst);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      xs[k+1]  <= {xs[k][61:0], 2'b00};
      rem[k+1] <= take ? diff[RW-1:0] : trial[RW-1:0];
      rt[k+1]  <= {rt[k][30:0], take};
      sd[k+1]  <= sd[k];
    end
  end

  assign out_valid = vld[STEPS];
  assign root      = rt[STEPS];
  assign side_out  = sd[STEPS];

endmodule
